// ----- src/rxno_pkg.sv -----
// Shared types, constants and the xorshift step of the noise oscillator.
package rxno_pkg;

  // Default sizing of the period counter and of the warm-up after a reseed
  localparam int unsigned PeriodBitsDef = 16;
  localparam int unsigned PrestepsDef   = 8;

  // Seed mapping: 1 + ((level * SeedScale) >> 16), level clamped to LevelOne
  localparam logic [30:0] SeedScale = 31'h7FFF_FFFE;
  localparam logic [16:0] LevelOne  = 17'h1_0000;

  // Saturation limits of a Q1.15 sample
  localparam logic signed [15:0] SampleMax = 16'sh7FFF;
  localparam logic signed [15:0] SampleMin = -16'sh8000;

  // One input item: one audio sample tick
  typedef struct packed {
    logic               restart;
    logic        [15:0] period_length;
    logic        [16:0] seed_level_a;
    logic        [16:0] seed_level_b;
    logic        [16:0] seed_level_c;
    logic signed [15:0] spread_a;
    logic signed [15:0] spread_b;
    logic signed [15:0] spread_c;
    logic signed [15:0] mix_ab;
    logic signed [15:0] mix_bc;
  } rxno_in_t;

  // One result item
  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               clipped;
  } rxno_out_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;   // latch the item, update the period counter
    logic seed;   // load the three generators from the seed levels
    logic step;   // advance the three generators once
    logic mul1;   // bipolar value times spread
    logic diff;   // pairwise differences
    logic mul2;   // differences times mix gains
    logic fin;    // round, saturate, write the output register
  } rxno_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic reseed; // the item at the input port starts a new period
  } rxno_sts_t;

  // One xorshift step: right 7, left 9, right 13
  function automatic logic [31:0] xs_step(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s >> 7);
    t = t ^ (t << 9);
    t = t ^ (t >> 13);
    return t;
  endfunction

endpackage

// ----- src/rxno_ctrl.sv -----
// Sequencer of the noise oscillator: one-hot state machine and output handshake.
module rxno_ctrl
  import rxno_pkg::*;
#(
  parameter int unsigned PRESTEPS = PrestepsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  rxno_sts_t sts_i,
  output rxno_cmd_t cmd_o
);

  localparam int unsigned WarmBits = (PRESTEPS > 0) ? $clog2(PRESTEPS + 1) : 1;
  localparam logic [WarmBits-1:0] WarmLoad = WarmBits'(PRESTEPS);
  localparam logic [WarmBits-1:0] WarmLast = WarmBits'(1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SEED = 8'b0000_0010,
    S_WARM = 8'b0000_0100,
    S_STEP = 8'b0000_1000,
    S_MUL1 = 8'b0001_0000,
    S_DIFF = 8'b0010_0000,
    S_MUL2 = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [WarmBits-1:0] warm_q, warm_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  // Output register can take a new item when empty or drained this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    warm_d      = warm_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.reseed ? S_SEED : S_STEP;
        end
      end
      S_SEED: begin
        cmd_o.seed = 1'b1;
        warm_d     = WarmLoad;
        state_d    = (PRESTEPS > 0) ? S_WARM : S_STEP;
      end
      S_WARM: begin
        cmd_o.step = 1'b1;
        warm_d     = warm_q - WarmLast;
        if (warm_q == WarmLast) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.fin   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      warm_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      warm_q      <= warm_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/rxno_dp.sv -----
// Datapath of the noise oscillator: period counter, generators, multipliers, output.
module rxno_dp
  import rxno_pkg::*;
#(
  parameter int unsigned PERIOD_BITS = PeriodBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rxno_in_t  in_data_i,
  input  rxno_cmd_t cmd_i,
  output rxno_sts_t sts_o,
  output rxno_out_t out_data_o
);

  // Compare width covers both the counter and the 16-bit period field
  localparam int unsigned CmpBits = (PERIOD_BITS > 16) ? PERIOD_BITS : 16;
  localparam logic [CmpBits-1:0] CntMax = CmpBits'({PERIOD_BITS{1'b1}});
  localparam logic signed [50:0] RoundHalf = 51'sd134217728;

  logic [PERIOD_BITS-1:0] cnt_q, cnt_d;
  logic [CmpBits-1:0]     len_raw, len_eff, cnt_ext;
  logic                   reseed;

  rxno_in_t          item_q;
  logic [31:0]       gen_q [3];
  logic [16:0]       level [3];
  logic [16:0]       lvl_clamp [3];
  logic [47:0]       seed_prod [3];
  logic [31:0]       seed_val [3];
  logic signed [15:0] spread [3];
  logic signed [15:0] bip [3];
  logic signed [31:0] r_q [3];
  logic signed [32:0] d_ab_q, d_bc_q;
  logic signed [48:0] p_ab_q, p_bc_q;
  logic signed [49:0] acc;
  logic signed [50:0] rnd;
  logic signed [22:0] y;
  rxno_out_t          out_q, out_d;

  // Effective period: zero acts as one, capped at the counter's range
  always_comb begin
    len_raw = CmpBits'(in_data_i.period_length);
    if (len_raw == '0) begin
      len_eff = CmpBits'(1);
    end else if (len_raw > CntMax) begin
      len_eff = CntMax;
    end else begin
      len_eff = len_raw;
    end
    cnt_ext = CmpBits'(cnt_q);
    reseed  = in_data_i.restart || (cnt_q == '0) || (cnt_ext >= len_eff);
    cnt_d   = (reseed ? '0 : cnt_q) + PERIOD_BITS'(1);
  end

  assign sts_o.reseed = reseed;

  // Item and period counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
  end

  // Seed values, one lane per generator
  assign level[0]  = item_q.seed_level_a;
  assign level[1]  = item_q.seed_level_b;
  assign level[2]  = item_q.seed_level_c;
  assign spread[0] = item_q.spread_a;
  assign spread[1] = item_q.spread_b;
  assign spread[2] = item_q.spread_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lvl_clamp[i] = (level[i] > LevelOne) ? LevelOne : level[i];
      seed_prod[i] = 48'(lvl_clamp[i]) * 48'(SeedScale);
      seed_val[i]  = seed_prod[i][47:16] + 32'd1;
      // low 16 bits minus 32768 is the low word with its top bit flipped
      bip[i]       = signed'({~gen_q[i][15], gen_q[i][14:0]});
    end
  end

  // Generators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        gen_q[i] <= '0;
      end
    end else if (cmd_i.seed) begin
      for (int i = 0; i < 3; i++) begin
        gen_q[i] <= seed_val[i];
      end
    end else if (cmd_i.step) begin
      for (int i = 0; i < 3; i++) begin
        gen_q[i] <= xs_step(gen_q[i]);
      end
    end
  end

  // Arithmetic pipeline, one register after each step
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      for (int i = 0; i < 3; i++) begin
        r_q[i] <= 32'(bip[i]) * 32'(spread[i]);
      end
    end
    if (cmd_i.diff) begin
      d_ab_q <= 33'(r_q[0]) - 33'(r_q[1]);
      d_bc_q <= 33'(r_q[1]) - 33'(r_q[2]);
    end
    if (cmd_i.mul2) begin
      p_ab_q <= 49'(d_ab_q) * 49'(item_q.mix_ab);
      p_bc_q <= 49'(d_bc_q) * 49'(item_q.mix_bc);
    end
  end

  // Round to Q1.15 and saturate
  always_comb begin
    acc   = 50'(p_bc_q) - 50'(p_ab_q);
    rnd   = 51'(acc) + RoundHalf;
    y     = rnd[50:28];
    out_d = '0;
    if (y > 23'(SampleMax)) begin
      out_d.sample_out = SampleMax;
      out_d.clipped    = 1'b1;
    end else if (y < 23'(SampleMin)) begin
      out_d.sample_out = SampleMin;
      out_d.clipped    = 1'b1;
    end else begin
      out_d.sample_out = y[15:0];
      out_d.clipped    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- src/reseeded_xorshift_noise_oscillator.sv -----
// Top level of the reseeded xorshift noise oscillator.
// Each input item is one audio sample tick and yields one result item. A tick that
// continues the current period runs through these steps before the next acceptance:
// the accept cycle, one generator step, spread multiply, differences, mix multiply and
// round/saturate into the output register; that step waits while the register is full.
// A tick that reseeds (restart, first tick, or the period counter reaching the period)
// adds the seed load and the warm-up steps of the shared xorshift update.
// The output register holds a finished item while the next one is accepted and worked on.
module reseeded_xorshift_noise_oscillator
  import rxno_pkg::*;
#(
  parameter int unsigned PERIOD_BITS = PeriodBitsDef,
  parameter int unsigned PRESTEPS    = PrestepsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rxno_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rxno_out_t out_data_o
);

  rxno_cmd_t cmd;
  rxno_sts_t sts;

  // Sequencer
  rxno_ctrl #(
    .PRESTEPS(PRESTEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  rxno_dp #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

endmodule

// ----- tb/reseeded_xorshift_noise_oscillator_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the reseeded xorshift noise oscillator: directed ticks, then random runs.
module reseeded_xorshift_noise_oscillator_tb
  import rxno_pkg::*;
();

  localparam int unsigned CntMax = (1 << PeriodBitsDef) - 1;
  localparam int NumDirected = 20;
  localparam int NumRandom   = 900;
  localparam int DrainCycles = 40;
  localparam int HoldOff     = 300;
  localparam rxno_out_t Silent = '0;

  // One row of the directed table
  typedef struct {
    rxno_in_t  item;
    bit        typed;
    rxno_out_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  rxno_in_t  in_data_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  rxno_out_t out_data_o;

  reseeded_xorshift_noise_oscillator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: three generator words and the period counter
  logic [31:0] noise_word [3] = '{default: '0};
  int unsigned tick_cnt = 0;
  rxno_out_t   sample_queue [$];
  int          err_cnt = 0;
  int          res_cnt = 0;

  // Random voice state: a parameter set held for a run of ticks
  rxno_in_t voice = '0;
  int       run_left = 0;
  bit       noisy = 1'b0;

  function automatic logic [31:0] xs_advance(input logic [31:0] s);
    s = s ^ (s >> 7);
    s = s ^ {s[22:0], 9'b0};
    s = s ^ (s >> 13);
    return s;
  endfunction

  // Seed word from a level, then the warm-up steps
  function automatic logic [31:0] warm_seed(input logic [16:0] level);
    logic [16:0] l;
    logic [63:0] prod;
    logic [31:0] s;
    int i;
    l = (level > LevelOne) ? LevelOne : level;
    prod = 64'(l) * 64'(SeedScale);
    s = 32'(64'd1 + (prod >> 16));
    for (i = 0; i < PrestepsDef; i++) s = xs_advance(s);
    return s;
  endfunction

  // One audio tick: update generators and counter, return the expected sample
  function automatic rxno_out_t osc_tick(input rxno_in_t it);
    int unsigned len;
    logic [16:0] lvl [3];
    longint spr [3];
    longint prod [3];
    longint acc, y;
    rxno_out_t res;
    int i;
    lvl[0] = it.seed_level_a;
    lvl[1] = it.seed_level_b;
    lvl[2] = it.seed_level_c;
    spr[0] = longint'(it.spread_a);
    spr[1] = longint'(it.spread_b);
    spr[2] = longint'(it.spread_c);
    len = it.period_length;
    if (len == 0) len = 1;
    if (len > CntMax) len = CntMax;
    if (it.restart || tick_cnt == 0 || tick_cnt >= len) begin
      tick_cnt = 0;
      for (i = 0; i < 3; i++) noise_word[i] = warm_seed(lvl[i]);
    end
    for (i = 0; i < 3; i++) begin
      noise_word[i] = xs_advance(noise_word[i]);
      prod[i] = (longint'(noise_word[i][15:0]) - 32768) * spr[i];
    end
    acc = (prod[1] - prod[2]) * longint'(it.mix_bc) - (prod[0] - prod[1]) * longint'(it.mix_ab);
    // round half up, floor shift down to Q1.15
    y = (acc + (longint'(1) <<< 27)) >>> 28;
    res.clipped = 1'b0;
    if (y > longint'(SampleMax)) begin
      y = longint'(SampleMax);
      res.clipped = 1'b1;
    end else if (y < longint'(SampleMin)) begin
      y = longint'(SampleMin);
      res.clipped = 1'b1;
    end
    res.sample_out = y[15:0];
    tick_cnt = (tick_cnt + 1) & CntMax;
    return res;
  endfunction

  function automatic rxno_in_t mk(input bit rs, input logic [15:0] per,
                                  input logic [16:0] la, input logic [16:0] lb,
                                  input logic [16:0] lc, input logic [15:0] sa,
                                  input logic [15:0] sb, input logic [15:0] sc,
                                  input logic [15:0] mab, input logic [15:0] mbc);
    rxno_in_t t;
    t.restart       = rs;
    t.period_length = per;
    t.seed_level_a  = la;
    t.seed_level_b  = lb;
    t.seed_level_c  = lc;
    t.spread_a      = sa;
    t.spread_b      = sb;
    t.spread_c      = sc;
    t.mix_ab        = mab;
    t.mix_bc        = mbc;
    return t;
  endfunction

  function automatic logic signed [15:0] rand_gain();
    case ($urandom_range(0, 9))
      0: return SampleMin;
      1: return SampleMax;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly legal levels, some above one and some full-width noise
  function automatic logic [16:0] rand_level();
    case ($urandom_range(0, 9))
      0: return 17'($urandom);
      1: return LevelOne;
      2: return 17'd0;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Short periods so reseeds come often; a few zero, long and full-width ones
  function automatic logic [15:0] rand_period();
    int k;
    k = $urandom_range(0, 19);
    if (k < 13) return 16'($urandom_range(1, 12));
    if (k < 15) return 16'd0;
    if (k < 18) return 16'($urandom_range(13, 300));
    return 16'($urandom);
  endfunction

  function automatic rxno_in_t draw_voice();
    return mk(1'b0, rand_period(), rand_level(), rand_level(), rand_level(),
              rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain());
  endfunction

  // Next random tick: runs of held parameters, some runs redrawn every tick
  function automatic rxno_in_t next_tick();
    rxno_in_t t;
    bit fresh;
    fresh = 1'b0;
    if (run_left == 0) begin
      run_left = $urandom_range(4, 40);
      noisy = ($urandom_range(0, 4) == 0);
      voice = draw_voice();
      fresh = 1'b1;
    end
    run_left--;
    t = noisy ? draw_voice() : voice;
    t.restart = (fresh && $urandom_range(0, 1) == 1) || ($urandom_range(0, 24) == 0);
    return t;
  endfunction

  // Sender: reset, directed table, random ticks, then drain and verdict
  initial begin
    dir_row_t dir_tab [NumDirected];
    rxno_in_t item;
    rxno_out_t pred;
    int n, gap;
    // first tick after reset, everything zero
    dir_tab[0]  = '{mk(1'b0, 16'h0000, 17'h00000, 17'h00000, 17'h00000, 16'h0000, 16'h0000,
                       16'h0000, 16'h0000, 16'h0000), 1'b1, Silent};
    // equal generators cancel in both differences
    dir_tab[1]  = '{mk(1'b0, 16'h0000, 17'h10000, 17'h10000, 17'h10000, 16'h7FFF, 16'h7FFF,
                       16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b1, Silent};
    dir_tab[2]  = '{mk(1'b1, 16'h0001, 17'h00000, 17'h00000, 17'h00000, 16'h8000, 16'h8000,
                       16'h8000, 16'h8000, 16'h8000), 1'b1, Silent};
    // level above one clamps to one, so a matches b and c
    dir_tab[3]  = '{mk(1'b1, 16'h0005, 17'h1FFFF, 17'h10000, 17'h10000, 16'h8000, 16'h8000,
                       16'h8000, 16'h7FFF, 16'h7FFF), 1'b1, Silent};
    // short period walked through its reseed
    dir_tab[4]  = '{mk(1'b1, 16'h0003, 17'h00000, 17'h10000, 17'h08000, 16'h7FFF, 16'h8000,
                       16'h7FFF, 16'h8000, 16'h7FFF), 1'b0, Silent};
    dir_tab[5]  = dir_tab[4];
    dir_tab[5].item.restart = 1'b0;
    dir_tab[6]  = dir_tab[5];
    dir_tab[7]  = dir_tab[5];
    // zero period reseeds on every tick
    dir_tab[8]  = '{mk(1'b0, 16'h0000, 17'h03039, 17'h0D431, 17'h00001, 16'h4000, 16'h4000,
                       16'hC000, 16'h4000, 16'h4000), 1'b0, Silent};
    dir_tab[9]  = dir_tab[8];
    // longest period
    dir_tab[10] = '{mk(1'b0, 16'hFFFF, 17'h1FFFF, 17'h0AAAA, 17'h15555, 16'h5555, 16'hAAAA,
                       16'h1234, 16'hFEDC, 16'h0F0F), 1'b0, Silent};
    dir_tab[11] = dir_tab[10];
    dir_tab[12] = dir_tab[10];
    dir_tab[13] = dir_tab[10];
    // large gains to drive saturation
    dir_tab[14] = '{mk(1'b0, 16'hFFFF, 17'h1FFFF, 17'h0AAAA, 17'h15555, 16'h7FFF, 16'h8000,
                       16'h7FFF, 16'h8000, 16'h8000), 1'b0, Silent};
    dir_tab[15] = '{mk(1'b1, 16'h0002, 17'h15555, 17'h0AAAA, 17'h00001, 16'h8000, 16'h7FFF,
                       16'h8000, 16'h7FFF, 16'h8000), 1'b0, Silent};
    dir_tab[16] = dir_tab[15];
    dir_tab[16].item.restart = 1'b0;
    // zero mix gains, then zero spreads
    dir_tab[17] = '{mk(1'b0, 16'h8000, 17'h12345, 17'h00F0F, 17'h0FFFF, 16'h7FFF, 16'h8000,
                       16'h1357, 16'h0000, 16'h0000), 1'b1, Silent};
    dir_tab[18] = '{mk(1'b0, 16'h8000, 17'h12345, 17'h00F0F, 17'h0FFFF, 16'h0000, 16'h0000,
                       16'h0000, 16'h8000, 16'h7FFF), 1'b1, Silent};
    dir_tab[19] = '{mk(1'b1, 16'h0007, 17'h00001, 17'h00002, 17'h00003, 16'h0001, 16'hFFFF,
                       16'h0001, 16'h0001, 16'hFFFF), 1'b0, Silent};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (n = 0; n < NumDirected + NumRandom; n++) begin
      item = (n < NumDirected) ? dir_tab[n].item : next_tick();
      // a stretch of back-to-back items, random gaps elsewhere
      gap = (n >= 300 && n < 400) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= item;
      do @(posedge clk_i); while (!in_ready_o);
      pred = osc_tick(item);
      if (n < NumDirected && dir_tab[n].typed) sample_queue.push_back(dir_tab[n].want);
      else sample_queue.push_back(pred);
    end
    in_valid_i <= 1'b0;

    while (sample_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("reseeded_xorshift_noise_oscillator_tb: PASS");
    end else begin
      $display("reseeded_xorshift_noise_oscillator_tb: FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, check against the oldest expectation
  initial begin
    int gap;
    rxno_out_t want;
    wait (rst_ni === 1'b1);
    forever begin
      if (res_cnt == 150) gap = HoldOff;
      else if (res_cnt >= 600 && res_cnt < 700) gap = 0;
      else gap = $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      res_cnt++;
      if (sample_queue.size() == 0) begin
        $error("unexpected result item: sample_out %0d clipped %0b",
               out_data_o.sample_out, out_data_o.clipped);
        err_cnt++;
      end else begin
        want = sample_queue.pop_front();
        if (out_data_o.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d", want.sample_out, out_data_o.sample_out);
          err_cnt++;
        end
        if (out_data_o.clipped !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, out_data_o.clipped);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("reseeded_xorshift_noise_oscillator_tb: FAIL");
    $finish;
  end

endmodule
